>>> rtl/rhmw_pkg.sv
// Package of the right-hand maze walker: constants, item types and control structs.
`timescale 1ns / 1ps
`default_nettype none

package rhmw_pkg;

  // Default and limits of the maze geometry.
  localparam int MaxGridDefault = 64;
  localparam int PosLimit       = 64;
  localparam logic [6:0] GridMin      = 7'd2;
  localparam logic [6:0] GridSizeRst  = 7'd64;

  // Headings, in the order of a left turn.
  localparam logic [1:0] DirUp    = 2'd0;
  localparam logic [1:0] DirLeft  = 2'd1;
  localparam logic [1:0] DirDown  = 2'd2;
  localparam logic [1:0] DirRight = 2'd3;

  // Heading increments for a quarter turn.
  localparam logic [1:0] TurnLeft  = 2'd1;
  localparam logic [1:0] TurnRight = 2'd3;

  // Item modes.
  localparam logic ModeLoad = 1'b0;
  localparam logic ModeStep = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [5:0] cell_row;
    logic [5:0] cell_col;
    logic       is_wall;
    logic       is_start;
  } in_item_t;

  typedef struct packed {
    logic       moved;
    logic [1:0] direction;
    logic [5:0] pos_row;
    logic [5:0] pos_col;
    logic       reached_exit;
    logic       stuck;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_PROBE,
    S_CHECK,
    S_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic do_load;
    logic start_step;
    logic probe_rd;
    logic advance;
    logic do_move;
    logic set_stuck;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_step;
    logic exit_done;
    logic nb_inside;
    logic nb_wall;
    logic last_try;
  } status_t;

endpackage

`default_nettype wire

>>> rtl/rhmw_in_if.sv
// Input channel interface of the maze walker: valid, ready and one input item.
`timescale 1ns / 1ps
`default_nettype none

interface rhmw_in_if;
  logic               valid;
  logic               ready;
  rhmw_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/rhmw_out_if.sv
// Output channel interface of the maze walker: valid, ready and one result item.
`timescale 1ns / 1ps
`default_nettype none

interface rhmw_out_if;
  logic                valid;
  logic                ready;
  rhmw_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/rhmw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module rhmw_ram #(
  parameter int Width = 1,
  parameter int Depth = 4096,
  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [Aw-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [Aw-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/rhmw_datapath.sv
// Datapath of the maze walker: position, heading, neighbour probe, wall memory, result register.
`timescale 1ns / 1ps
`default_nettype none

module rhmw_datapath #(
  parameter int MAX_GRID = rhmw_pkg::MaxGridDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [6:0]          cfg_wdata_i,
  input  wire rhmw_pkg::in_item_t  in_data_i,
  output rhmw_pkg::out_item_t      out_data_o,
  input  wire rhmw_pkg::cmd_t      cmd_i,
  output rhmw_pkg::status_t        st_o
);
  import rhmw_pkg::*;

  localparam int Depth   = MAX_GRID * MAX_GRID;
  localparam int Aw      = $clog2(Depth);
  localparam int GridLim = (MAX_GRID < PosLimit) ? MAX_GRID : PosLimit;

  logic [6:0] eff_q, eff_d;
  logic [5:0] cur_row_q, cur_col_q;
  logic [1:0] heading_q;
  logic       exit_q;
  in_item_t   item_q;
  logic [1:0] dir_q;
  logic [1:0] try_q;
  logic       moved_q, stuck_q;
  out_item_t  out_q;

  logic [6:0]    nb_row, nb_col;
  logic          nb_under, nb_inside, nb_edge;
  logic [Aw-1:0] rd_addr, wr_addr;
  logic          load_ok, ram_we, ram_rdata;

  // The configured size is clamped once, when it is written.
  always_comb begin
    eff_d = cfg_wdata_i;
    if (cfg_wdata_i < GridMin) begin
      eff_d = GridMin;
    end else if (cfg_wdata_i > 7'(GridLim)) begin
      eff_d = 7'(GridLim);
    end
  end

  // Neighbour of the current cell in the probed heading.
  always_comb begin
    nb_row   = {1'b0, cur_row_q};
    nb_col   = {1'b0, cur_col_q};
    nb_under = 1'b0;
    case (dir_q)
      DirUp: begin
        if (cur_row_q == 6'd0) nb_under = 1'b1;
        else nb_row = nb_row - 7'd1;
      end
      DirLeft: begin
        if (cur_col_q == 6'd0) nb_under = 1'b1;
        else nb_col = nb_col - 7'd1;
      end
      DirDown: nb_row = nb_row + 7'd1;
      default: nb_col = nb_col + 7'd1;
    endcase
    nb_inside = !nb_under && (nb_row < eff_q) && (nb_col < eff_q);
    nb_edge   = (nb_row == 7'd0) || (nb_col == 7'd0) ||
                (nb_row == eff_q - 7'd1) || (nb_col == eff_q - 7'd1);
  end

  assign rd_addr = Aw'(Aw'(nb_row[5:0]) * Aw'(MAX_GRID)) + Aw'(nb_col[5:0]);
  assign wr_addr = Aw'(Aw'(item_q.cell_row) * Aw'(MAX_GRID)) + Aw'(item_q.cell_col);
  assign load_ok = (32'(item_q.cell_row) < 32'(MAX_GRID)) &&
                   (32'(item_q.cell_col) < 32'(MAX_GRID));
  assign ram_we  = cmd_i.do_load && load_ok;

  rhmw_ram #(
    .Width (1),
    .Depth (Depth)
  ) u_wall_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_addr),
    .wdata_i (item_q.is_wall),
    .re_i    (cmd_i.probe_rd),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // Walker state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_q     <= 7'(GridLim);
      cur_row_q <= '0;
      cur_col_q <= '0;
      heading_q <= DirUp;
      exit_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        eff_q <= eff_d;
      end
      if (ram_we && item_q.is_start) begin
        cur_row_q <= item_q.cell_row;
        cur_col_q <= item_q.cell_col;
        heading_q <= DirUp;
        exit_q    <= 1'b0;
      end
      if (cmd_i.do_move) begin
        cur_row_q <= nb_row[5:0];
        cur_col_q <= nb_col[5:0];
        heading_q <= dir_q;
        exit_q    <= nb_edge;
      end
    end
  end

  // Per-item working registers and the result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q  <= in_data_i;
      moved_q <= 1'b0;
      stuck_q <= 1'b0;
    end
    if (cmd_i.start_step) begin
      dir_q <= heading_q + TurnRight;
      try_q <= 2'd0;
    end
    if (cmd_i.advance) begin
      dir_q <= dir_q + TurnLeft;
      try_q <= try_q + 2'd1;
    end
    if (cmd_i.do_move) begin
      moved_q <= 1'b1;
    end
    if (cmd_i.set_stuck) begin
      stuck_q <= 1'b1;
    end
    if (cmd_i.out_load) begin
      out_q.moved        <= moved_q;
      out_q.direction    <= heading_q;
      out_q.pos_row      <= cur_row_q;
      out_q.pos_col      <= cur_col_q;
      out_q.reached_exit <= exit_q;
      out_q.stuck        <= stuck_q;
    end
  end

  assign out_data_o = out_q;

  assign st_o.is_step   = (item_q.mode == ModeStep);
  assign st_o.exit_done = exit_q;
  assign st_o.nb_inside = nb_inside;
  assign st_o.nb_wall   = ram_rdata;
  assign st_o.last_try  = (try_q == 2'd3);

endmodule

`default_nettype wire

>>> rtl/rhmw_ctrl.sv
// Controller state machine of the maze walker: sequences loads, probes and result transfers.
`timescale 1ns / 1ps
`default_nettype none

module rhmw_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output rhmw_pkg::cmd_t         cmd_o,
  input  wire rhmw_pkg::status_t st_i
);
  import rhmw_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_START;
      end
      S_START: begin
        if (st_i.is_step && !st_i.exit_done) state_d = S_PROBE;
        else state_d = S_DONE;
      end
      S_PROBE: begin
        if (st_i.nb_inside) state_d = S_CHECK;
        else if (st_i.last_try) state_d = S_DONE;
      end
      S_CHECK: begin
        if (!st_i.nb_wall || st_i.last_try) state_d = S_DONE;
        else state_d = S_PROBE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs and commands.
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_START: begin
        cmd_o.do_load    = !st_i.is_step;
        cmd_o.start_step = st_i.is_step && !st_i.exit_done;
      end
      S_PROBE: begin
        if (st_i.nb_inside) cmd_o.probe_rd = 1'b1;
        else if (st_i.last_try) cmd_o.set_stuck = 1'b1;
        else cmd_o.advance = 1'b1;
      end
      S_CHECK: begin
        if (!st_i.nb_wall) cmd_o.do_move = 1'b1;
        else if (st_i.last_try) cmd_o.set_stuck = 1'b1;
        else cmd_o.advance = 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> rtl/right_hand_maze_walker_core.sv
// Top level of the right-hand maze walker: controller, datapath and their wiring.
//
// The block follows the right-hand wall through a square maze held in an
// on-chip wall memory of MAX_GRID x MAX_GRID bits. Items arrive on the input
// channel in_i and each one produces exactly one result on out_o; both
// channels use a valid/ready handshake and a transfer happens on a rising
// edge of clk_i where both are high. A load item writes one wall bit and may
// place the walker; a step item turns right, then left until an open cell is
// found, and moves there. The grid size register is written through
// cfg_we_i/cfg_wdata_i; the user must write it only while the block is idle, as
// the block itself does not enforce this. It is clamped to between 2 and the
// smaller of MAX_GRID and 64. A load, or a step after the exit, goes straight
// to the result register; any other step is set up and then probes neighbours
// in turn: one inside the grid is read from the wall memory through its
// registered read and then checked, one outside the grid is skipped, and the
// result register is loaded at the end.
// One item is worked on at a time; the next input transfer is taken once the
// result has moved to the output register, so a stalled receiver holds back
// at most one waiting result while the next item is already being worked on.
// Reset (rst_ni, asynchronous, active low) puts the walker at row 0, column 0
// facing up, clears the exit flag and sets the grid size to its maximum; the
// wall memory is not cleared, so cells must be loaded before they are walked.
`timescale 1ns / 1ps
`default_nettype none

module right_hand_maze_walker_core #(
  parameter int MAX_GRID = rhmw_pkg::MaxGridDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [6:0] cfg_wdata_i,
  rhmw_in_if.sink         in_i,
  rhmw_out_if.source      out_o
);
  import rhmw_pkg::*;

  cmd_t    cmd;
  status_t st;

  // The controller owns the handshakes and the sequence of each item.
  rhmw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .st_i        (st)
  );

  // The datapath holds the walker state, the wall memory and the result.
  rhmw_datapath #(
    .MAX_GRID (MAX_GRID)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_i.data),
    .out_data_o  (out_o.data),
    .cmd_i       (cmd),
    .st_o        (st)
  );

endmodule

`default_nettype wire

>>> rtl/rhmw_checker.sv
// Port-level checker of the maze walker and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rhmw_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_i,
  input wire logic                out_valid_i,
  input wire logic                out_ready_i,
  input wire rhmw_pkg::out_item_t out_data_i
);

  logic       in_acc, out_acc;
  logic [1:0] pend_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Items taken in whose results have not yet been transferred.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
    end else begin
      pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed or dropped while stalled");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> pend_q != 2'd0)
    else $error("result transferred without a pending item");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two items outstanding");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("second item taken while one is in progress");

  a_stuck_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.stuck |-> !out_data_i.moved && !out_data_i.reached_exit)
    else $error("stuck result also reports a move or an exit");

endmodule

bind right_hand_maze_walker_core rhmw_checker u_rhmw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

`default_nettype wire
